// ----- design/qrm_pkg.sv -----
`default_nettype none

package qrm_pkg;

  // Field widths of the streaming channels.
  localparam int COMP_W = 16;
  localparam int ENTRY_W = 16;
  localparam int THR_W = 32;

  // Number of matrix entries, and so of divider lanes.
  localparam int LANES = 9;

  // Internal widths. Squares stay below 2^31, cross products are signed 32 bits,
  // the squared length reaches 2^32 and numerators reach +/-2^32.
  localparam int SQ_W = 31;
  localparam int PROD_W = 32;
  localparam int LEN_W = 33;
  localparam int NUM_W = 34;
  localparam int MAG_W = 33;

  // Quotient bits produced by the divider, one per stage.
  localparam int QBITS = 16;
  localparam int FRAC_SHIFT = 15;
  localparam int REM_W = MAG_W + FRAC_SHIFT;
  localparam int DEN_W = LEN_W + 1;
  localparam int CMP_W = DEN_W + QBITS;

  localparam logic signed [ENTRY_W-1:0] ONE_Q14 = 16'sd16384;

  typedef struct packed {
    logic signed [COMP_W-1:0] q_x;
    logic signed [COMP_W-1:0] q_y;
    logic signed [COMP_W-1:0] q_z;
    logic signed [COMP_W-1:0] q_w;
  } quat_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QBITS-1:0] quo;
    logic             neg;
  } div_lane_t;

  typedef struct packed {
    div_lane_t [LANES-1:0] lane;
    logic [DEN_W-1:0]      den;
    logic                  degenerate;
  } div_item_t;

  typedef struct packed {
    logic [LANES-1:0][ENTRY_W-1:0] ent;
    logic                          degenerate;
  } result_t;

endpackage

`default_nettype wire

// ----- design/qrm_quat_if.sv -----
`default_nettype none

interface qrm_quat_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] q_x;
  logic signed [15:0] q_y;
  logic signed [15:0] q_z;
  logic signed [15:0] q_w;

  modport source(output valid, output q_x, output q_y, output q_z, output q_w, input ready);
  modport sink(input valid, input q_x, input q_y, input q_z, input q_w, output ready);
endinterface

`default_nettype wire

// ----- design/qrm_matrix_if.sv -----
`default_nettype none

interface qrm_matrix_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] m00;
  logic signed [15:0] m01;
  logic signed [15:0] m02;
  logic signed [15:0] m10;
  logic signed [15:0] m11;
  logic signed [15:0] m12;
  logic signed [15:0] m20;
  logic signed [15:0] m21;
  logic signed [15:0] m22;
  logic               degenerate;

  modport source(output valid, output m00, output m01, output m02, output m10, output m11,
                 output m12, output m20, output m21, output m22, output degenerate,
                 input ready);
  modport sink(input valid, input m00, input m01, input m02, input m10, input m11,
               input m12, input m20, input m21, input m22, input degenerate,
               output ready);
endinterface

`default_nettype wire

// ----- design/qrm_cfg_if.sv -----
`default_nettype none

interface qrm_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- design/qrm_front.sv -----
`default_nettype none

module qrm_front (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [qrm_pkg::THR_W-1:0] thr,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire qrm_pkg::quat_t            in_data,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output qrm_pkg::div_item_t             out_data
);

  logic [2:0] vld;
  logic [2:0] rdy;

  // Stage 1: squares and cross products.
  logic [qrm_pkg::SQ_W-1:0]          xx, yy, zz, ww;
  logic signed [qrm_pkg::PROD_W-1:0] xy, xz, yz, wx, wy, wz;
  logic signed [qrm_pkg::PROD_W-1:0] xx_c, yy_c, zz_c, ww_c;
  logic signed [qrm_pkg::PROD_W-1:0] xy_c, xz_c, yz_c, wx_c, wy_c, wz_c;

  // Stage 2: squared length and the nine signed numerators.
  logic [qrm_pkg::LEN_W-1:0]                  len;
  logic [qrm_pkg::LANES-1:0][qrm_pkg::NUM_W-1:0] num;
  logic [qrm_pkg::LEN_W-1:0]                  len_next;
  logic [qrm_pkg::LANES-1:0][qrm_pkg::NUM_W-1:0] num_next;

  // Stage 3: divider operands.
  qrm_pkg::div_item_t item;
  qrm_pkg::div_item_t item_next;

  assign rdy[2] = !vld[2] || out_ready;
  assign rdy[1] = !vld[1] || rdy[2];
  assign rdy[0] = !vld[0] || rdy[1];
  assign in_ready = rdy[0];
  assign out_valid = vld[2];
  assign out_data = item;

  always_comb begin
    xx_c = in_data.q_x * in_data.q_x;
    yy_c = in_data.q_y * in_data.q_y;
    zz_c = in_data.q_z * in_data.q_z;
    ww_c = in_data.q_w * in_data.q_w;
    xy_c = in_data.q_x * in_data.q_y;
    xz_c = in_data.q_x * in_data.q_z;
    yz_c = in_data.q_y * in_data.q_z;
    wx_c = in_data.q_w * in_data.q_x;
    wy_c = in_data.q_w * in_data.q_y;
    wz_c = in_data.q_w * in_data.q_z;
  end

  always_comb begin
    logic signed [qrm_pkg::NUM_W-1:0] sx, sy, sz, sw;
    logic signed [qrm_pkg::NUM_W-1:0] pxy, pxz, pyz, pwx, pwy, pwz;
    sx = $signed({3'b000, xx});
    sy = $signed({3'b000, yy});
    sz = $signed({3'b000, zz});
    sw = $signed({3'b000, ww});
    pxy = qrm_pkg::NUM_W'(xy);
    pxz = qrm_pkg::NUM_W'(xz);
    pyz = qrm_pkg::NUM_W'(yz);
    pwx = qrm_pkg::NUM_W'(wx);
    pwy = qrm_pkg::NUM_W'(wy);
    pwz = qrm_pkg::NUM_W'(wz);
    len_next = qrm_pkg::LEN_W'(sx + sy + sz + sw);
    num_next[0] = sx + sw - sy - sz;
    num_next[1] = (pxy - pwz) <<< 1;
    num_next[2] = (pxz + pwy) <<< 1;
    num_next[3] = (pxy + pwz) <<< 1;
    num_next[4] = sy + sw - sx - sz;
    num_next[5] = (pyz - pwx) <<< 1;
    num_next[6] = (pxz - pwy) <<< 1;
    num_next[7] = (pyz + pwx) <<< 1;
    num_next[8] = sz + sw - sx - sy;
  end

  // The dividend carries the rounding half: (|n| * 2^15 + s) / (2 * s).
  always_comb begin
    logic [qrm_pkg::NUM_W-1:0] neg_num;
    logic [qrm_pkg::MAG_W-1:0] mag;
    item_next.den = {len, 1'b0};
    item_next.degenerate = (len <= {1'b0, thr});
    for (int k = 0; k < qrm_pkg::LANES; k++) begin
      neg_num = qrm_pkg::NUM_W'(0) - num[k];
      item_next.lane[k].neg = num[k][qrm_pkg::NUM_W-1];
      mag = num[k][qrm_pkg::NUM_W-1] ? neg_num[qrm_pkg::MAG_W-1:0]
                                       : num[k][qrm_pkg::MAG_W-1:0];
      item_next.lane[k].rem = (qrm_pkg::REM_W'(mag) << qrm_pkg::FRAC_SHIFT)
                              + qrm_pkg::REM_W'(len);
      item_next.lane[k].quo = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= in_valid;
      end
      if (rdy[1]) begin
        vld[1] <= vld[0];
      end
      if (rdy[2]) begin
        vld[2] <= vld[1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      xx <= xx_c[qrm_pkg::SQ_W-1:0];
      yy <= yy_c[qrm_pkg::SQ_W-1:0];
      zz <= zz_c[qrm_pkg::SQ_W-1:0];
      ww <= ww_c[qrm_pkg::SQ_W-1:0];
      xy <= xy_c;
      xz <= xz_c;
      yz <= yz_c;
      wx <= wx_c;
      wy <= wy_c;
      wz <= wz_c;
    end
    if (rdy[1]) begin
      len <= len_next;
      num <= num_next;
    end
    if (rdy[2]) begin
      item <= item_next;
    end
  end

  function automatic logic quotient_fits(qrm_pkg::div_item_t x);
    logic ok;
    ok = 1'b1;
    for (int k = 0; k < qrm_pkg::LANES; k++) begin
      if (qrm_pkg::CMP_W'(x.lane[k].rem) >= (qrm_pkg::CMP_W'(x.den) << qrm_pkg::QBITS)) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  // A real length makes every quotient fit in the divider's sixteen bits.
  a_quotient_fits: assert property (@(posedge clk) disable iff (rst)
    vld[2] && !item.degenerate |-> quotient_fits(item))
    else $error("dividend too large for the divider");

endmodule

`default_nettype wire

// ----- design/qrm_divider.sv -----
`default_nettype none

module qrm_divider (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire qrm_pkg::div_item_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output qrm_pkg::div_item_t out_data
);

  localparam int LAST = qrm_pkg::QBITS - 1;

  logic [qrm_pkg::QBITS-1:0] vld;
  logic [qrm_pkg::QBITS-1:0] rdy;
  qrm_pkg::div_item_t        st [qrm_pkg::QBITS];
  qrm_pkg::div_item_t        src [qrm_pkg::QBITS];
  qrm_pkg::div_item_t        st_next [qrm_pkg::QBITS];

  assign in_ready = rdy[0];
  assign out_valid = vld[LAST];
  assign out_data = st[LAST];

  for (genvar j = 0; j < qrm_pkg::QBITS; j++) begin : g_stage
    // Stage j settles quotient bit QBITS-1-j by one restoring step.
    localparam int B = qrm_pkg::QBITS - 1 - j;

    if (j == 0) begin : g_first
      assign src[j] = in_data;
      assign rdy[j] = !vld[j] || rdy[j+1];
    end else if (j == LAST) begin : g_last
      assign src[j] = st[j-1];
      assign rdy[j] = !vld[j] || out_ready;
    end else begin : g_mid
      assign src[j] = st[j-1];
      assign rdy[j] = !vld[j] || rdy[j+1];
    end

    always_comb begin
      logic [qrm_pkg::CMP_W-1:0] rem_ext;
      logic [qrm_pkg::CMP_W-1:0] den_sh;
      logic [qrm_pkg::CMP_W-1:0] diff;
      st_next[j] = src[j];
      den_sh = qrm_pkg::CMP_W'(src[j].den) << B;
      for (int k = 0; k < qrm_pkg::LANES; k++) begin
        rem_ext = qrm_pkg::CMP_W'(src[j].lane[k].rem);
        diff = rem_ext - den_sh;
        if (rem_ext >= den_sh) begin
          st_next[j].lane[k].rem = diff[qrm_pkg::REM_W-1:0];
          st_next[j].lane[k].quo[B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (rdy[j]) begin
        vld[j] <= (j == 0) ? in_valid : vld[(j == 0) ? 0 : j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[j]) begin
        st[j] <= st_next[j];
      end
    end
  end

  function automatic logic remainders_below(qrm_pkg::div_item_t x);
    logic ok;
    ok = 1'b1;
    for (int k = 0; k < qrm_pkg::LANES; k++) begin
      if (qrm_pkg::CMP_W'(x.lane[k].rem) >= qrm_pkg::CMP_W'(x.den)) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  // After the last step every remainder must be smaller than the divisor.
  a_remainder: assert property (@(posedge clk) disable iff (rst)
    vld[LAST] && !st[LAST].degenerate |-> remainders_below(st[LAST]))
    else $error("divider remainder not reduced");

endmodule

`default_nettype wire

// ----- design/qrm_back.sv -----
`default_nettype none

module qrm_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire qrm_pkg::div_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output qrm_pkg::result_t        out_data
);

  localparam logic [qrm_pkg::ENTRY_W-1:0] POS_MAX = {1'b0, {(qrm_pkg::ENTRY_W-1){1'b1}}};
  localparam logic [qrm_pkg::ENTRY_W-1:0] NEG_MAX = {1'b1, {(qrm_pkg::ENTRY_W-1){1'b0}}};

  logic             vld;
  qrm_pkg::result_t res;
  qrm_pkg::result_t res_next;

  function automatic logic [qrm_pkg::ENTRY_W-1:0] sat_entry(logic [qrm_pkg::QBITS-1:0] q,
                                                          logic neg);
    logic [qrm_pkg::QBITS:0] negq;
    negq = (qrm_pkg::QBITS+1)'(0) - {1'b0, q};
    if (neg) begin
      return (q > NEG_MAX) ? NEG_MAX : negq[qrm_pkg::ENTRY_W-1:0];
    end else begin
      return (q > POS_MAX) ? POS_MAX : q;
    end
  endfunction

  always_comb begin
    res_next.degenerate = in_data.degenerate;
    for (int k = 0; k < qrm_pkg::LANES; k++) begin
      if (in_data.degenerate) begin
        res_next.ent[k] = (k % 4 == 0) ? qrm_pkg::ONE_Q14 : '0;
      end else begin
        res_next.ent[k] = sat_entry(in_data.lane[k].quo, in_data.lane[k].neg);
      end
    end
  end

  assign in_ready = !vld || out_ready;
  assign out_valid = vld;
  assign out_data = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      res <= res_next;
    end
  end

  a_identity: assert property (@(posedge clk) disable iff (rst)
    vld && res.degenerate |-> res.ent[0] == qrm_pkg::ONE_Q14 && res.ent[4] == qrm_pkg::ONE_Q14
      && res.ent[8] == qrm_pkg::ONE_Q14 && res.ent[1] == '0 && res.ent[5] == '0)
    else $error("degenerate result is not the identity");

  // Entries of a normalised rotation never exceed one in magnitude.
  a_bounded: assert property (@(posedge clk) disable iff (rst)
    vld && !res.degenerate |-> $signed(res.ent[0]) <= qrm_pkg::ONE_Q14
      && $signed(res.ent[0]) >= -qrm_pkg::ONE_Q14
      && $signed(res.ent[1]) <= qrm_pkg::ONE_Q14
      && $signed(res.ent[1]) >= -qrm_pkg::ONE_Q14)
    else $error("matrix entry out of the unit range");

endmodule

`default_nettype wire

// ----- design/quaternion_to_rotation_matrix_top.sv -----
`default_nettype none

// Channel  | Dir | Request contents                           | Handshake
// ---------+-----+--------------------------------------------+------------------
// quat     | in  | q_x, q_y, q_z, q_w, signed Q2.14           | valid / ready
// matrix   | out | m00..m22 signed Q2.14, degenerate flag     | valid / ready
// cfg      | in  | zero_length_threshold, unsigned Q4.28      | valid / ready
//
// One request is taken every cycle unless a stall at the output holds the pipeline back.
// Each result passes through twenty register stages: three front stages, sixteen divider
// stages and one output register.
// The divider is a sixteen-stage restoring divider, one quotient bit per stage.
// Reset is synchronous and clears every valid bit and sets the threshold to one LSB.
// A stall at the output holds each stage that is full; empty stages still fill.

module quaternion_to_rotation_matrix_top (
  input wire logic      clk,
  input wire logic      rst,
  qrm_quat_if.sink      quat,
  qrm_matrix_if.source  matrix,
  qrm_cfg_if.sink       cfg
);

  // The threshold register is always ready. Writes must come only while the pipeline is
  // empty (not enforced here), and the front stage reads it directly, no copy per request.
  logic [qrm_pkg::THR_W-1:0] thr;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= qrm_pkg::THR_W'(1);
    end else if (cfg.valid) begin
      thr <= cfg.data;
    end
  end

  qrm_pkg::quat_t     quat_data;
  qrm_pkg::div_item_t front_data;
  qrm_pkg::div_item_t div_data;
  qrm_pkg::result_t   res_data;
  logic               front_valid, front_ready;
  logic               div_valid, div_ready;

  assign quat_data.q_x = quat.q_x;
  assign quat_data.q_y = quat.q_y;
  assign quat_data.q_z = quat.q_z;
  assign quat_data.q_w = quat.q_w;

  // Products, squared length, numerators and the zero-length test.
  qrm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .thr       (thr),
    .in_valid  (quat.valid),
    .in_ready  (quat.ready),
    .in_data   (quat_data),
    .out_valid (front_valid),
    .out_ready (front_ready),
    .out_data  (front_data)
  );

  // Nine division lanes side by side sharing one divisor, twice the squared length.
  qrm_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_data   (front_data),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_data  (div_data)
  );

  // Sign, saturation and the identity override, into the output register.
  qrm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (div_valid),
    .in_ready  (div_ready),
    .in_data   (div_data),
    .out_valid (matrix.valid),
    .out_ready (matrix.ready),
    .out_data  (res_data)
  );

  assign matrix.m00 = res_data.ent[0];
  assign matrix.m01 = res_data.ent[1];
  assign matrix.m02 = res_data.ent[2];
  assign matrix.m10 = res_data.ent[3];
  assign matrix.m11 = res_data.ent[4];
  assign matrix.m12 = res_data.ent[5];
  assign matrix.m20 = res_data.ent[6];
  assign matrix.m21 = res_data.ent[7];
  assign matrix.m22 = res_data.ent[8];
  assign matrix.degenerate = res_data.degenerate;

endmodule

`default_nettype wire
